// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication; the consequent may open with a delay
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/sinmx_pkg.sv =====
// ----------------------------------------------------------------------------
// sinmx_pkg
// Widths, limits, sequencer states and control bundle of the sine series unit.
// ----------------------------------------------------------------------------
package sinmx_pkg;

    localparam int X_W     = 31;
    localparam int CNT_W   = 5;
    localparam int SUM_W   = 37;
    localparam int MAG_W   = 31;
    localparam int HALF_W  = 31;
    localparam int U_W     = 2 * HALF_W;
    localparam int PP_W    = HALF_W + MAG_W;
    localparam int PROD_W  = U_W + MAG_W;
    localparam int ACC_W   = 64;
    localparam int DIGIT_W = 8;
    localparam int DVD_W   = 64;
    localparam int STEPS   = DVD_W / DIGIT_W;
    localparam int STEP_W  = $clog2(STEPS);

    localparam logic [U_W-1:0] WIDE_CAP = 62'h2000_0000_0000_0000;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh2000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -64'sh2000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] SUM_MAX = 64'sh0000_000F_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] SUM_MIN = -64'sh0000_0010_0000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_ACCUM,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic mul_sum;
        logic div_start;
        logic div_take;
        logic accum;
        logic finish;
        logic k_odd;
    } ctrl_t;

endpackage

// ===== hdl/sinmx_mul.sv =====
// ----------------------------------------------------------------------------
// sinmx_mul
// Shared 31x31 multiplier: term times magnitude in two halves, then scale.
// ----------------------------------------------------------------------------
module sinmx_mul
    import sinmx_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic             clk,
    input  ctrl_t            ctl,
    input  logic [U_W-1:0]   u,
    input  logic [MAG_W-1:0] m,
    output logic [U_W-1:0]   q,
    output logic             q_clip
);

    logic [PP_W-1:0]   pp_reg;
    logic [PP_W-1:0]   pp_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [HALF_W-1:0] half_sel;
    logic [PROD_W-1:0] shr;

    always_comb
    begin
        half_sel  = ctl.mul_hi ? u[U_W-1:HALF_W] : u[HALF_W-1:0];
        pp_next   = PP_W'(half_sel) * PP_W'(m);
        prod_next = prod_reg + {pp_reg, HALF_W'(0)};
        shr       = prod_reg >> FRAC_BITS;
        q_clip    = shr > PROD_W'(WIDE_CAP);
        q         = q_clip ? WIDE_CAP : shr[U_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_lo || ctl.mul_hi)
        begin
            pp_reg <= pp_next;
        end
        if (ctl.mul_hi)
        begin
            prod_reg <= PROD_W'(pp_reg);
        end
        else if (ctl.mul_sum)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== hdl/sinmx_div.sv =====
// ----------------------------------------------------------------------------
// sinmx_div
// Digit-serial divider by a small integer, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module sinmx_div
    import sinmx_pkg::*;
#(
    parameter int DIV_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [U_W-1:0]   dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [U_W-1:0]   quotient
);

    logic [DVD_W-1:0]  work_reg;
    logic [DVD_W-1:0]  work_next;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W-1:0]  d_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_comb
    begin
        logic [DIV_W-1:0]   r;
        logic [DIV_W:0]     t;
        logic [DIGIT_W-1:0] qd;
        r  = rem_reg;
        qd = '0;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            t = {r, work_reg[DVD_W-1-i]};
            if (t >= {1'b0, d_reg})
            begin
                t = t - {1'b0, d_reg};
                qd[DIGIT_W-1-i] = 1'b1;
            end
            r = t[DIV_W-1:0];
        end
        rem_next  = r;
        work_next = {work_reg[DVD_W-DIGIT_W-1:0], qd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= DVD_W'(dividend);
            rem_reg  <= '0;
            d_reg    <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[U_W-1:0];

endmodule

// ===== hdl/sinmx_ctrl.sv =====
// ----------------------------------------------------------------------------
// sinmx_ctrl
// Sequencer: term counter and step control for the shared multiplier and divider.
// ----------------------------------------------------------------------------
module sinmx_ctrl
    import sinmx_pkg::*;
#(
    parameter int MAX_TERMS = 16,
    parameter int K_W       = $clog2(MAX_TERMS + 1),
    parameter int DIV_W     = K_W + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CNT_W-1:0] term_count,
    input  logic             div_done,
    input  logic             out_busy,
    output logic             in_stall,
    output ctrl_t            ctl,
    output logic [DIV_W-1:0] divisor
);

    state_t         state_reg;
    state_t         state_next;
    logic [K_W-1:0] k_reg;
    logic [K_W-1:0] n_reg;
    logic           second_reg;
    logic [K_W-1:0] n_eff;
    logic [5:0]     tc_ext;
    logic           last;

    always_comb
    begin
        tc_ext = 6'(term_count);
        n_eff  = (tc_ext > 6'(MAX_TERMS)) ? K_W'(MAX_TERMS) : K_W'(tc_ext);
        last   = k_reg == n_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (n_eff == '0) ? S_FINISH : S_MUL_LO;
                end
            end
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_MUL_SUM;
            S_MUL_SUM:  state_next = S_DIV_LOAD;
            S_DIV_LOAD: state_next = S_DIV_RUN;
            S_DIV_RUN:
            begin
                if (div_done)
                begin
                    state_next = second_reg ? S_ACCUM : S_MUL_LO;
                end
            end
            S_ACCUM:    state_next = last ? S_FINISH : S_MUL_LO;
            S_FINISH:
            begin
                if (!out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        ctl.k_odd = k_reg[0];
        unique case (state_reg)
            S_IDLE:     ctl.load      = in_valid;
            S_MUL_LO:   ctl.mul_lo    = 1'b1;
            S_MUL_HI:   ctl.mul_hi    = 1'b1;
            S_MUL_SUM:  ctl.mul_sum   = 1'b1;
            S_DIV_LOAD: ctl.div_start = 1'b1;
            S_DIV_RUN:  ctl.div_take  = div_done;
            S_ACCUM:    ctl.accum     = 1'b1;
            S_FINISH:   ctl.finish    = !out_busy;
            default:    ctl           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            n_reg      <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.load)
            begin
                n_reg      <= n_eff;
                k_reg      <= K_W'(1);
                second_reg <= 1'b0;
            end
            else if (ctl.div_take && !second_reg)
            begin
                second_reg <= 1'b1;
            end
            else if (ctl.accum && !last)
            begin
                k_reg      <= k_reg + 1'b1;
                second_reg <= 1'b0;
            end
        end
    end

    assign in_stall = state_reg != S_IDLE;
    assign divisor  = {k_reg, second_reg};

endmodule

// ===== hdl/sine_minus_x_taylor_series_top.sv =====
// ----------------------------------------------------------------------------
// sine_minus_x_taylor_series_top: sin(x) - x series, shared multiplier and divider
// Series: n terms (n = term_count, capped at MAX_TERMS), each built by two multiply-divide passes.
// Flow: one item at a time; in_stall stays high until its result is written, later while a result is held off.
// Reset: rst_n low clears sequencer, divider control and output valid at once.
// ----------------------------------------------------------------------------
module sine_minus_x_taylor_series_top
    import sinmx_pkg::*;
#(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 28
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [X_W-1:0]   x_value,
    input  logic [CNT_W-1:0]        term_count,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SUM_W-1:0] sum_value,
    output logic                    saturated
);

    localparam int K_W   = $clog2(MAX_TERMS + 1);
    localparam int DIV_W = K_W + 1;

    ctrl_t                    ctl;
    logic [DIV_W-1:0]         divisor;
    logic                     div_done;
    logic [U_W-1:0]           quotient;
    logic [U_W-1:0]           q;
    logic                     q_clip;

    logic [MAG_W-1:0]         m_reg;
    logic                     neg_reg;
    logic [U_W-1:0]           u_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     clip_reg;
    logic                     clip_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [SUM_W-1:0]  sum_value_reg;
    logic                     saturated_reg;

    logic [MAG_W-1:0]         x_mag;
    logic signed [ACC_W-1:0]  u_ext;
    logic signed [ACC_W-1:0]  acc_sum;
    logic                     acc_over;
    logic signed [ACC_W-1:0]  fin;
    logic                     fin_over;

    sinmx_ctrl #(
        .MAX_TERMS (MAX_TERMS),
        .K_W       (K_W),
        .DIV_W     (DIV_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .term_count (term_count),
        .div_done   (div_done),
        .out_busy   (out_valid_reg && out_stall),
        .in_stall   (in_stall),
        .ctl        (ctl),
        .divisor    (divisor)
    );

    sinmx_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .ctl    (ctl),
        .u      (u_reg),
        .m      (m_reg),
        .q      (q),
        .q_clip (q_clip)
    );

    sinmx_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (q),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        x_mag = x_value[X_W-1] ? MAG_W'(~x_value + 1'b1) : MAG_W'(x_value);
        u_ext = signed'(ACC_W'(u_reg));

        acc_sum  = (ctl.k_odd ^ neg_reg) ? acc_reg - u_ext : acc_reg + u_ext;
        priority if (acc_sum > ACC_MAX)
        begin
            acc_next = ACC_MAX;
            acc_over = 1'b1;
        end
        else if (acc_sum < ACC_MIN)
        begin
            acc_next = ACC_MIN;
            acc_over = 1'b1;
        end
        else
        begin
            acc_next = acc_sum;
            acc_over = 1'b0;
        end

        priority if (acc_reg > SUM_MAX)
        begin
            fin      = SUM_MAX;
            fin_over = 1'b1;
        end
        else if (acc_reg < SUM_MIN)
        begin
            fin      = SUM_MIN;
            fin_over = 1'b1;
        end
        else
        begin
            fin      = acc_reg;
            fin_over = 1'b0;
        end

        priority if (ctl.load)
        begin
            clip_next = 1'b0;
        end
        else if ((ctl.div_start && q_clip) || (ctl.accum && acc_over))
        begin
            clip_next = 1'b1;
        end
        else
        begin
            clip_next = clip_reg;
        end

        priority if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clip_reg <= clip_next;
        if (ctl.load)
        begin
            m_reg   <= x_mag;
            neg_reg <= x_value[X_W-1];
            u_reg   <= U_W'(x_mag);
            acc_reg <= '0;
        end
        else
        begin
            if (ctl.div_take)
            begin
                u_reg <= quotient;
            end
            if (ctl.accum)
            begin
                acc_reg <= acc_next;
            end
        end
        if (ctl.finish)
        begin
            sum_value_reg <= fin[SUM_W-1:0];
            saturated_reg <= clip_reg || fin_over;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum_value = sum_value_reg;
    assign saturated = saturated_reg;

endmodule

// ===== hdl/sinmx_checker.sv =====
// ----------------------------------------------------------------------------
// sinmx_checker
// Port-level checks of the sine series unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sinmx_checker
    import sinmx_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic [CNT_W-1:0]        term_count,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [SUM_W-1:0] sum_value,
    input logic                    saturated
);

    logic in_take;

    assign in_take = in_valid && !in_stall;

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                 out_valid && $stable(sum_value) && $stable(saturated))

    `ASSERT_NEXT(a_busy_after_take, in_take, in_stall)

    `ASSERT_IMP(a_zero_terms, in_take && (term_count == '0) && !out_valid,
                ##2 (out_valid && (sum_value == '0) && !saturated))

    `ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind sine_minus_x_taylor_series_top sinmx_checker u_sinmx_checker (.*);
